>>> hdl/sbt_pkg.sv
// sbt_pkg: shared types and constants for the strided byte transform
// used by strided_byte_transform and its port checker; depends on nothing
`timescale 1ns / 1ps

package sbt_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 4;
  localparam int unsigned PosW    = 5;
  localparam int unsigned CfgIdxW = 8;

  // masks and thresholds of the operations
  localparam logic [7:0] LowNibbleMask = 8'h0F;
  localparam logic [7:0] LowSevenMask  = 8'h7F;
  localparam logic [7:0] HighNibbleMask = 8'hF0;
  localparam logic [7:0] TopBitValue   = 8'd128;

  // fixed stride of the full-amount operations
  localparam logic [PosW-1:0] PairStride = 5'd2;
  // offset added to the band to form the packed stride
  localparam logic [PosW-1:0] StrideBase = 5'd2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_OP_SELECT = 8'd0,
    REG_AMOUNT    = 8'd1
  } reg_idx_e;

  // transform operations
  typedef enum logic [OpW-1:0] {
    OP_XOR_L4_P0     = 4'd0,
    OP_XOR_L4_P1     = 4'd1,
    OP_ADD_L4_P0     = 4'd2,
    OP_ADD_L4_P1     = 4'd3,
    OP_XOR_AMT_P0    = 4'd4,
    OP_XOR_AMT_P1    = 4'd5,
    OP_ADD_AMT_P0    = 4'd6,
    OP_ADD_AMT_P1    = 4'd7,
    OP_BAND_XOR      = 4'd8,
    OP_HI_XOR_L7     = 4'd9,
    OP_LO_XOR_L7     = 4'd10,
    OP_HI_ADD_L7     = 4'd11,
    OP_LO_ADD_L7     = 4'd12,
    OP_BAND_ADD      = 4'd13,
    OP_XOR_HIGH_P0   = 4'd14,
    OP_XOR_HIGH_P1   = 4'd15
  } op_e;

endpackage

>>> hdl/strided_byte_transform.sv
// strided_byte_transform: per-byte reversible transform with stride counter
// depends on sbt_pkg (types, masks, register indexes)
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | sink      | in_valid_i/in_stall_o | in_byte_i, in_last_i
//  out     | source    | out_valid_o/out_stall_i | out_byte_o, out_last_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one byte per cycle while the output is not stalled: each transfer is modified by
// one compare and one add or xor and lands in the output register on the next edge
// reset clears the configuration registers, the position counter and the output valid
// in_stall_o rises only while a result is held and out_stall_i is high
`timescale 1ns / 1ps

module strided_byte_transform (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sbt_pkg::ByteW-1:0]    in_byte_i,
  input  logic                         in_last_i,
  // output stream
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sbt_pkg::ByteW-1:0]    out_byte_o,
  output logic                         out_last_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sbt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sbt_pkg::ByteW-1:0]    cfg_data_i
);

  sbt_pkg::op_e                 op_q;
  logic [sbt_pkg::ByteW-1:0]    amount_q;
  logic [sbt_pkg::PosW-1:0]     pos_q, pos_d;
  logic                         out_valid_q;
  logic [sbt_pkg::ByteW-1:0]    out_byte_q, out_byte_d;
  logic                         out_last_q;

  logic                         in_xfer;
  logic                         out_free;
  logic [3:0]                   band;
  logic [3:0]                   l4;
  logic [6:0]                   l7;
  logic [sbt_pkg::PosW-1:0]     stride;
  logic [sbt_pkg::PosW:0]       pos_inc;
  logic                         hit0, hit1;
  logic                         band_match;
  logic                         top_set;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !out_free;
  assign in_xfer     = in_valid_i && out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= sbt_pkg::OP_XOR_L4_P0;
      amount_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sbt_pkg::REG_OP_SELECT: op_q <= sbt_pkg::op_e'(cfg_data_i[sbt_pkg::OpW-1:0]);
        sbt_pkg::REG_AMOUNT:    amount_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // argument fields and stride
  assign band = amount_q[7:4];
  assign l4   = amount_q[3:0] & sbt_pkg::LowNibbleMask[3:0];
  assign l7   = amount_q[6:0] & sbt_pkg::LowSevenMask[6:0];

  always_comb begin
    case (op_q) inside
      [sbt_pkg::OP_XOR_AMT_P0 : sbt_pkg::OP_ADD_AMT_P1]: stride = sbt_pkg::PairStride;
      default: stride = {1'b0, band} + sbt_pkg::StrideBase;
    endcase
  end

  assign hit0       = pos_q == '0;
  assign hit1       = pos_q == sbt_pkg::PosW'(1);
  assign band_match = ((in_byte_i & sbt_pkg::HighNibbleMask) >> 4) == {4'd0, band};
  assign top_set    = in_byte_i >= sbt_pkg::TopBitValue;

  // byte transform
  always_comb begin
    out_byte_d = in_byte_i;
    case (op_q)
      sbt_pkg::OP_XOR_L4_P0:   if (hit0) out_byte_d = in_byte_i ^ {4'd0, l4};
      sbt_pkg::OP_XOR_L4_P1:   if (hit1) out_byte_d = in_byte_i ^ {4'd0, l4};
      sbt_pkg::OP_ADD_L4_P0:   if (hit0) out_byte_d = in_byte_i + {4'd0, l4};
      sbt_pkg::OP_ADD_L4_P1:   if (hit1) out_byte_d = in_byte_i + {4'd0, l4};
      sbt_pkg::OP_XOR_AMT_P0:  if (hit0) out_byte_d = in_byte_i ^ amount_q;
      sbt_pkg::OP_XOR_AMT_P1:  if (hit1) out_byte_d = in_byte_i ^ amount_q;
      sbt_pkg::OP_ADD_AMT_P0:  if (hit0) out_byte_d = in_byte_i + amount_q;
      sbt_pkg::OP_ADD_AMT_P1:  if (hit1) out_byte_d = in_byte_i + amount_q;
      sbt_pkg::OP_BAND_XOR:    if (band_match) out_byte_d = in_byte_i ^ {4'd0, l4};
      sbt_pkg::OP_HI_XOR_L7:   if (top_set) out_byte_d = in_byte_i ^ {1'b0, l7};
      sbt_pkg::OP_LO_XOR_L7:   if (!top_set) out_byte_d = in_byte_i ^ {1'b0, l7};
      sbt_pkg::OP_HI_ADD_L7:
        if (top_set) out_byte_d = {in_byte_i[7], in_byte_i[6:0] + l7};
      sbt_pkg::OP_LO_ADD_L7:
        if (!top_set) out_byte_d = {in_byte_i[7], in_byte_i[6:0] + l7};
      sbt_pkg::OP_BAND_ADD:
        if (band_match) out_byte_d = {in_byte_i[7:4], in_byte_i[3:0] + l4};
      sbt_pkg::OP_XOR_HIGH_P0: if (hit0) out_byte_d = in_byte_i ^ {l4, 4'd0};
      sbt_pkg::OP_XOR_HIGH_P1: if (hit1) out_byte_d = in_byte_i ^ {l4, 4'd0};
      default: out_byte_d = in_byte_i;
    endcase
  end

  // position counter next value
  assign pos_inc = {1'b0, pos_q} + 6'd1;

  always_comb begin
    if (in_last_i || (pos_inc >= {1'b0, stride})) begin
      pos_d = '0;
    end else begin
      pos_d = pos_inc[sbt_pkg::PosW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        pos_q <= pos_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_byte_q <= out_byte_d;
      out_last_q <= in_last_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

>>> hdl/sbt_checker.sv
// sbt_checker: port-level assertions for strided_byte_transform
// depends on sbt_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module sbt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [sbt_pkg::ByteW-1:0]  out_byte_o,
  input logic                       out_last_o
);

  // a held result keeps its valid
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("out_valid_o dropped while stalled");

  // a held result keeps its payload
  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(out_byte_o) && $stable(out_last_o)))
    else $error("output payload changed while stalled");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("in_stall_o without a held result");

  // every input transfer shows a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("input transfer without a result");

endmodule

bind strided_byte_transform sbt_checker u_sbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);

>>> test/tb_top.sv
// tb_top: self-checking bench for strided_byte_transform, one byte per transfer
// depends on sbt_pkg and the strided_byte_transform rtl; reads no files
// directed table first, then random buffers under three idle mixes
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 300000;

  // clock, reset and block ports
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = '0;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  // expected output byte plus its end-of-buffer flag
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // directed plan rows: a register write or one byte, with an optional fixed answer
  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_e;
  typedef struct {
    row_kind_e  kind;
    logic [7:0] idx;
    logic [7:0] val;
    logic       last;
    logic       pinned;
    logic [7:0] want;
  } row_t;

  // shadow of the block's registers and position counter
  sbt_pkg::op_e shadow_op = sbt_pkg::OP_XOR_L4_P0;
  logic [7:0]   shadow_amt = '0;
  logic [4:0]   stride_pos = '0;

  out_beat_t  due_beats[$];
  logic       pin_on = 1'b0;
  logic [7:0] pin_byte = '0;
  int         tx_idle = 10;
  int         rx_idle = 55;
  int         mismatches = 0;
  int         bytes_seen = 0;
  int         writes_seen = 0;
  int         cycles = 0;

  strided_byte_transform u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predicted byte for the current registers; advances the position counter
  function automatic logic [7:0] transform_byte(input logic [7:0] b, input logic last);
    logic [3:0] band;
    logic [7:0] lo4;
    logic [7:0] lo7;
    logic [4:0] span;
    logic       at0;
    logic       at1;
    logic [7:0] r;
    band = shadow_amt[7:4];
    lo4  = shadow_amt & sbt_pkg::LowNibbleMask;
    lo7  = shadow_amt & sbt_pkg::LowSevenMask;
    span = (shadow_op >= sbt_pkg::OP_XOR_AMT_P0 && shadow_op <= sbt_pkg::OP_ADD_AMT_P1) ?
           sbt_pkg::PairStride : {1'b0, band} + sbt_pkg::StrideBase;
    at0  = (stride_pos == 5'd0);
    at1  = (stride_pos == 5'd1);
    r    = b;
    case (shadow_op)
      sbt_pkg::OP_XOR_L4_P0:   if (at0) r = b ^ lo4;
      sbt_pkg::OP_XOR_L4_P1:   if (at1) r = b ^ lo4;
      sbt_pkg::OP_ADD_L4_P0:   if (at0) r = b + lo4;
      sbt_pkg::OP_ADD_L4_P1:   if (at1) r = b + lo4;
      sbt_pkg::OP_XOR_AMT_P0:  if (at0) r = b ^ shadow_amt;
      sbt_pkg::OP_XOR_AMT_P1:  if (at1) r = b ^ shadow_amt;
      sbt_pkg::OP_ADD_AMT_P0:  if (at0) r = b + shadow_amt;
      sbt_pkg::OP_ADD_AMT_P1:  if (at1) r = b + shadow_amt;
      sbt_pkg::OP_BAND_XOR:    if (b[7:4] == band) r = b ^ lo4;
      sbt_pkg::OP_HI_XOR_L7:   if (b >= sbt_pkg::TopBitValue) r = b ^ lo7;
      sbt_pkg::OP_LO_XOR_L7:   if (b < sbt_pkg::TopBitValue) r = b ^ lo7;
      sbt_pkg::OP_HI_ADD_L7:
        if (b >= sbt_pkg::TopBitValue) r = {b[7], b[6:0] + lo7[6:0]};
      sbt_pkg::OP_LO_ADD_L7:
        if (b < sbt_pkg::TopBitValue) r = {b[7], b[6:0] + lo7[6:0]};
      sbt_pkg::OP_BAND_ADD:    if (b[7:4] == band) r = {b[7:4], b[3:0] + lo4[3:0]};
      sbt_pkg::OP_XOR_HIGH_P0: if (at0) r = b ^ {lo4[3:0], 4'h0};
      default:                 if (at1) r = b ^ {lo4[3:0], 4'h0};
    endcase
    // wrap at the stride, restart after the last byte of a buffer
    if (last || ({1'b0, stride_pos} + 6'd1 >= {1'b0, span})) stride_pos = '0;
    else stride_pos = stride_pos + 5'd1;
    return r;
  endfunction

  // watch transfers on all three channels
  always @(posedge clk_i) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_ni) begin
      // input transfer: predict with the registers in force now
      if (in_valid_i && !in_stall_o) begin
        got.data = transform_byte(in_byte_i, in_last_i);
        got.last = in_last_i;
        if (pin_on) got.data = pin_byte;
        due_beats.push_back(got);
        bytes_seen++;
      end
      // register writes, masked to width; other indexes are dropped
      if (cfg_valid_i && cfg_ready_o) begin
        writes_seen++;
        if (cfg_index_i == sbt_pkg::REG_OP_SELECT) shadow_op = sbt_pkg::op_e'(cfg_data_i[3:0]);
        else if (cfg_index_i == sbt_pkg::REG_AMOUNT) shadow_amt = cfg_data_i;
      end
      // output transfer: compare with the oldest prediction
      if (out_valid_o && !out_stall_i) begin
        if (due_beats.size() == 0) begin
          $error("unexpected output transfer: out_byte %h out_last %b",
                 out_byte_o, out_last_o);
          mismatches++;
        end else begin
          want = due_beats.pop_front();
          if (out_byte_o !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, out_byte_o);
            mismatches++;
          end
          if (out_last_o !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, out_last_o);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver stalls at the current rate
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle);
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one byte transfer; valid stays high afterwards until the caller drops it
  task automatic push_byte(input logic [7:0] b, input logic last,
                           input logic pinned, input logic [7:0] want);
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    pin_on     <= pinned;
    pin_byte   <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // register write once the stream has drained
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_beats.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    row_t       plan[$];
    logic [3:0] op_code;
    logic [7:0] amt;
    logic [7:0] b;
    int         burst;
    int         left;
    left = 0;
    amt  = '0;

    // directed: reset state, extremes of every operation, register change mid-buffer
    plan = '{
      '{ROW_BYTE,  8'd0,                   8'hA5, 1'b0, 1'b1, 8'hA5},
      '{ROW_BYTE,  8'd0,                   8'h00, 1'b1, 1'b1, 8'h00},
      '{ROW_WRITE, sbt_pkg::REG_AMOUNT,    8'h3C, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'hFF, 1'b0, 1'b1, 8'hF3},
      '{ROW_BYTE,  8'd0,                   8'h80, 1'b0, 1'b1, 8'h80},
      '{ROW_BYTE,  8'd0,                   8'h12, 1'b1, 1'b1, 8'h12},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'hF7, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'hF0, 1'b0, 1'b1, 8'hF0},
      '{ROW_BYTE,  8'd0,                   8'hF0, 1'b0, 1'b1, 8'h2C},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h08, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, sbt_pkg::REG_AMOUNT,    8'hFF, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'hF3, 1'b0, 1'b1, 8'hFC},
      '{ROW_BYTE,  8'd0,                   8'hE3, 1'b0, 1'b1, 8'hE3},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h0B, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'hFF, 1'b0, 1'b1, 8'hFE},
      '{ROW_BYTE,  8'd0,                   8'h7F, 1'b0, 1'b1, 8'h7F},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h0C, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'h01, 1'b0, 1'b1, 8'h00},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h0D, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'hFF, 1'b0, 1'b1, 8'hFE},
      '{ROW_WRITE, sbt_pkg::REG_AMOUNT,    8'h7F, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h09, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'h80, 1'b0, 1'b1, 8'hFF},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h0A, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'h00, 1'b0, 1'b1, 8'h7F},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h0F, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, sbt_pkg::REG_AMOUNT,    8'hE1, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'h11, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'h22, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'h33, 1'b0, 1'b0, 8'h00},
      // counter past the new stride of two: no phase matches
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h04, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'h44, 1'b0, 1'b1, 8'h44},
      '{ROW_BYTE,  8'd0,                   8'h44, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h05, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'h5A, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h06, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'hC3, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h01, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'h0F, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h0E, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'h96, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h02, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'hFE, 1'b0, 1'b0, 8'h00},
      '{ROW_WRITE, sbt_pkg::REG_OP_SELECT, 8'h03, 1'b0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'd0,                   8'h69, 1'b1, 1'b0, 8'h00}
    };

    // reset
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].val);
      else push_byte(plan[i].val, plan[i].last, plan[i].pinned, plan[i].want);
    end

    // random buffers, registers rewritten between bursts, under three idle mixes
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle = (mode == 0) ? 10 : (mode == 1) ? 55 : 0;
      rx_idle = (mode == 0) ? 55 : (mode == 1) ? 10 : 0;
      for (int seg = 0; seg < 20; seg++) begin
        op_code = (seg < 16) ? seg[3:0] : 4'($urandom_range(15));
        // upper nibble is junk that the register must mask off
        write_reg(sbt_pkg::REG_OP_SELECT, {4'($urandom_range(15)), op_code});
        if (seg == 0 || $urandom_range(9) != 0) begin
          case ($urandom_range(5))
            0:       amt = 8'h00;
            1:       amt = 8'hFF;
            2:       amt = sbt_pkg::LowNibbleMask;
            3:       amt = sbt_pkg::HighNibbleMask;
            default: amt = 8'($urandom);
          endcase
          write_reg(sbt_pkg::REG_AMOUNT, amt);
        end
        if ($urandom_range(7) == 0)
          write_reg(8'($urandom_range(255, sbt_pkg::REG_AMOUNT + 1)), 8'($urandom));
        burst = $urandom_range(40, 8);
        for (int k = 0; k < burst; k++) begin
          if (left == 0)
            left = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : $urandom_range(40, 2);
          b = 8'($urandom);
          // band operations need matching high nibbles to do anything
          if ((op_code == sbt_pkg::OP_BAND_XOR || op_code == sbt_pkg::OP_BAND_ADD) &&
              $urandom_range(1))
            b[7:4] = amt[7:4];
          left--;
          push_byte(b, left == 0, 1'b0, 8'h00);
        end
      end
    end

    // drain
    in_valid_i <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("ran %0d bytes through %0d register writes, all sixteen operations,",
             bytes_seen, writes_seen);
    $display("with sender and receiver idling in turn and then back to back");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
